// ===== design/hang_detect_watchdog_top_defines.svh =====
// Assertion macros shared by the watchdog checker.
`ifndef HANG_DETECT_WATCHDOG_TOP_DEFINES_SVH
`define HANG_DETECT_WATCHDOG_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HDW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/hdw_pkg.sv =====
// Shared constants for the hang detection watchdog.
`default_nettype none

package hdw_pkg;

	// Width of the wrapping millisecond time base.
	localparam int TIME_BITS = 32;
	localparam int TIMEOUT_BITS = 32;
	localparam int CFG_INDEX_BITS = 1;

	// Timeout value that disables a limit.
	localparam logic [TIMEOUT_BITS-1:0] NEVER_MS = '1;

	// Reset values of the configuration registers.
	localparam logic [TIMEOUT_BITS-1:0] HANG_TIMEOUT_RST = TIMEOUT_BITS'(128);
	localparam logic [TIMEOUT_BITS-1:0] PERMAHANG_TIMEOUT_RST = TIMEOUT_BITS'(8192);

	// Request kinds.
	localparam logic [1:0] REQ_ACTIVITY = 2'd0;
	localparam logic [1:0] REQ_WAIT = 2'd1;
	localparam logic [1:0] REQ_EXPIRY = 2'd2;

	// Report kinds.
	localparam logic [1:0] REPORT_NONE = 2'd0;
	localparam logic [1:0] REPORT_HANG_ENDED = 2'd1;
	localparam logic [1:0] REPORT_PERMAHANG = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HANG_TIMEOUT = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PERMAHANG_TIMEOUT = 1'b1;

endpackage

`default_nettype wire

// ===== design/hang_detect_watchdog_top.sv =====
// Top level of the two-level hang detection watchdog.
//
// Usage: requests arrive on the in channel (in_valid / in_ready) with
// req_type (activity, wait, timer expiry) and the current time now_ms.
// Each request yields exactly one result on the out channel (out_valid /
// out_ready): report_kind, hang_length_ms, hang_began, timer_armed and
// timer_deadline_ms.
// A request lands in the input register when it is accepted and moves on
// into the result register, which drives out_valid. Throughput is one
// request per cycle while the receiver does not stall; the watchdog
// state is updated as a request moves from the input register into the
// result register, so the next request sees the updated state.
// When the receiver stalls, the result register holds its result and the
// input register holds one more request; in_ready drops only when both
// are full.
// The cfg channel writes hang_timeout_ms (index 0) and
// permahang_timeout_ms (index 1); it is always ready and must be used
// only while no request is in flight.
// Reset restores the timeouts to 128 ms and 8192 ms, marks the worker as
// waiting, disarms the timer and empties both registers.
`default_nettype none

module hang_detect_watchdog_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [1:0]                            req_type,
	input  wire logic [hdw_pkg::TIME_BITS-1:0]         now_ms,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [1:0]                                 report_kind,
	output logic [hdw_pkg::TIME_BITS-1:0]              hang_length_ms,
	output logic                                       hang_began,
	output logic                                       timer_armed,
	output logic [hdw_pkg::TIME_BITS-1:0]              timer_deadline_ms,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [hdw_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [hdw_pkg::TIMEOUT_BITS-1:0]      cfg_data
);

	localparam int TB = hdw_pkg::TIME_BITS;

	// Configuration registers.
	logic [hdw_pkg::TIMEOUT_BITS-1:0] hang_timeout_q;
	logic [hdw_pkg::TIMEOUT_BITS-1:0] permahang_timeout_q;

	// Watchdog state.
	logic          waiting_q;
	logic          hanging_q;
	logic          armed_q;
	logic [TB-1:0] last_activity_q;
	logic [TB-1:0] hang_start_q;
	logic [TB-1:0] expiry_q;

	// Input register.
	logic          valid_s1;
	logic [1:0]    req_type_s1;
	logic [TB-1:0] now_s1;

	// Next-state and result values.
	logic          waiting_d;
	logic          hanging_d;
	logic          armed_d;
	logic [TB-1:0] last_activity_d;
	logic [TB-1:0] hang_start_d;
	logic [TB-1:0] expiry_d;
	logic [1:0]    report_d;
	logic [TB-1:0] length_d;
	logic          began_d;

	logic          advance_s1;
	logic          hang_en;
	logic          perma_en;
	logic [TB-1:0] late_diff;
	logic          is_late;
	logic [TB-1:0] elapsed;

	// The input register moves on whenever the result register is free or drained.
	assign advance_s1 = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance_s1;
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hang_timeout_q <= hdw_pkg::HANG_TIMEOUT_RST;
			permahang_timeout_q <= hdw_pkg::PERMAHANG_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hdw_pkg::CFG_HANG_TIMEOUT: hang_timeout_q <= cfg_data;
				hdw_pkg::CFG_PERMAHANG_TIMEOUT: permahang_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			now_s1 <= now_ms;
		end
	end

	// Timing terms: lateness against the deadline and time since last activity.
	assign hang_en = (hang_timeout_q != hdw_pkg::NEVER_MS);
	assign perma_en = (permahang_timeout_q != hdw_pkg::NEVER_MS);
	assign late_diff = now_s1 - expiry_q;
	assign is_late = !late_diff[TB-1] && hang_en &&
		(late_diff > TB'(hang_timeout_q >> 1));
	assign elapsed = now_s1 - last_activity_q;

	// Event handling for the request in the input register.
	always_comb begin
		waiting_d = waiting_q;
		hanging_d = hanging_q;
		armed_d = armed_q;
		last_activity_d = last_activity_q;
		hang_start_d = hang_start_q;
		expiry_d = expiry_q;
		report_d = hdw_pkg::REPORT_NONE;
		length_d = '0;
		began_d = 1'b0;
		case (req_type_s1)
			hdw_pkg::REQ_ACTIVITY: begin
				if (waiting_q) begin
					waiting_d = 1'b0;
				end else if (hanging_q) begin
					report_d = hdw_pkg::REPORT_HANG_ENDED;
					length_d = now_s1 - hang_start_q;
					hanging_d = 1'b0;
				end
				last_activity_d = now_s1;
				expiry_d = now_s1 + TB'(hang_timeout_q);
				armed_d = hang_en;
			end
			hdw_pkg::REQ_WAIT: begin
				if (!waiting_q) begin
					armed_d = 1'b0;
					last_activity_d = now_s1;
					if (hanging_q) begin
						report_d = hdw_pkg::REPORT_HANG_ENDED;
						length_d = now_s1 - hang_start_q;
						hanging_d = 1'b0;
					end
					waiting_d = 1'b1;
				end
			end
			hdw_pkg::REQ_EXPIRY: begin
				if (armed_q) begin
					armed_d = 1'b0;
					if (is_late) begin
						waiting_d = 1'b1;
						hanging_d = 1'b0;
					end else if (perma_en && (elapsed >= TB'(permahang_timeout_q))) begin
						waiting_d = 1'b1;
						hanging_d = 1'b0;
						report_d = hdw_pkg::REPORT_PERMAHANG;
						length_d = TB'(permahang_timeout_q);
					end else begin
						if (!hanging_q && hang_en && (elapsed >= TB'(hang_timeout_q))) begin
							hang_start_d = last_activity_q;
							hanging_d = 1'b1;
							began_d = 1'b1;
						end
						// now + (limit - elapsed) reduces to last activity + limit.
						if (perma_en) begin
							expiry_d = last_activity_q + TB'(permahang_timeout_q);
							armed_d = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Watchdog state commits as the request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b1;
			hanging_q <= 1'b0;
			armed_q <= 1'b0;
			last_activity_q <= '0;
			hang_start_q <= '0;
			expiry_q <= '0;
		end else if (valid_s1 && advance_s1) begin
			waiting_q <= waiting_d;
			hanging_q <= hanging_d;
			armed_q <= armed_d;
			last_activity_q <= last_activity_d;
			hang_start_q <= hang_start_d;
			expiry_q <= expiry_d;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance_s1) begin
			out_valid <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s1) begin
			report_kind <= report_d;
			hang_length_ms <= length_d;
			hang_began <= began_d;
			timer_armed <= armed_d;
			timer_deadline_ms <= armed_d ? expiry_d : '0;
		end
	end

endmodule

`default_nettype wire

// ===== design/hdw_checker.sv =====
// Port-level checker for the hang detection watchdog, with its bind.
`default_nettype none
`include "hang_detect_watchdog_top_defines.svh"

module hdw_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [1:0]                    report_kind,
	input wire logic [hdw_pkg::TIME_BITS-1:0] hang_length_ms,
	input wire logic                          hang_began,
	input wire logic                          timer_armed,
	input wire logic [hdw_pkg::TIME_BITS-1:0] timer_deadline_ms
);

	// A result without a report carries no hang length.
	`HDW_ASSERT_NOW(a_len_zero, out_valid && (report_kind == hdw_pkg::REPORT_NONE), hang_length_ms == '0, "hang length without report")

	// A disarmed timer shows a zero deadline.
	`HDW_ASSERT_NOW(a_deadline_zero, out_valid && !timer_armed, timer_deadline_ms == '0, "deadline shown while disarmed")

	// A hang start never comes with a report, and a permanent hang leaves the timer off.
	`HDW_ASSERT_NOW(a_began_alone, out_valid && (hang_began || (report_kind == hdw_pkg::REPORT_PERMAHANG)), (report_kind == hdw_pkg::REPORT_NONE) != (report_kind == hdw_pkg::REPORT_PERMAHANG && !timer_armed && !hang_began) || (hang_began && report_kind == hdw_pkg::REPORT_NONE), "bad hang start or permanent hang result")

	// A stalled result stays valid.
	`HDW_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind hang_detect_watchdog_top hdw_checker u_hdw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.report_kind(report_kind),
	.hang_length_ms(hang_length_ms),
	.hang_began(hang_began),
	.timer_armed(timer_armed),
	.timer_deadline_ms(timer_deadline_ms)
);

`default_nettype wire
